### src/ptt_pkg.sv
package ptt_pkg;

    // request field widths
    localparam int MODE_W   = 2;
    localparam int PREFIX_W = 32;
    localparam int PLEN_W   = 6;
    localparam int TRUST_W  = 32;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = PLEN_W + PREFIX_W;

    // packed stream widths, padded to whole bytes
    localparam int IN_RAW_W     = MODE_W + PREFIX_W + PLEN_W + TRUST_W;
    localparam int IN_TDATA_W   = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W    = STATUS_W + TRUST_W;
    localparam int OUT_TDATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    // result codes
    localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NEW  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the request word
        logic match;  // register match and free vectors
        logic exec;   // apply the operation, read the value store
        logic resp;   // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_busy;  // result register full and not taken this cycle
    } t_stat;

endpackage

### src/ptt_ctrl.sv
module ptt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  ptt_pkg::t_stat i_stat,
    output ptt_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (!i_stat.out_busy) begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/ptt_dp.sv
module ptt_dp #(
    parameter int ENTRIES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ptt_pkg::t_cmd                   i_cmd,
    output ptt_pkg::t_stat                  o_stat,
    input  logic [ptt_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [ptt_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int IDX_W = $clog2(ENTRIES);

    // captured request
    logic [ptt_pkg::MODE_W-1:0]  r_mode;
    logic [ptt_pkg::KEY_W-1:0]   r_req_key;
    logic [ptt_pkg::TRUST_W-1:0] r_req_trust;

    // table rows: key compare is per row, value store is a memory
    logic [ENTRIES-1:0]          r_valid;
    logic [ptt_pkg::KEY_W-1:0]   r_keys [ENTRIES];
    logic [ptt_pkg::TRUST_W-1:0] r_trust_mem [ENTRIES];
    logic [ptt_pkg::TRUST_W-1:0] r_rd_trust;

    // search results
    logic [ENTRIES-1:0] r_match;
    logic [ENTRIES-1:0] r_free;

    // operation outcome
    logic [ptt_pkg::STATUS_W-1:0] r_status;
    logic                         r_lookup_hit;

    // result register
    logic                           r_out_valid;
    logic [ptt_pkg::STATUS_W-1:0]   r_out_status;
    logic [ptt_pkg::TRUST_W-1:0]    r_out_trust;

    logic                         w_hit;
    logic [IDX_W-1:0]             w_hit_idx;
    logic                         w_free_any;
    logic [ENTRIES-1:0]           w_free_oh;
    logic [IDX_W-1:0]             w_free_idx;
    logic                         w_set;
    logic                         w_clr;
    logic                         w_mem_we;
    logic [IDX_W-1:0]             w_mem_wa;
    logic [ptt_pkg::STATUS_W-1:0] w_status;
    logic                         w_lookup_hit;

    // request word: mode, prefix, plen, trust_in from bit 0 up
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode      <= i_s_tdata[1:0];
            r_req_key   <= {i_s_tdata[39:34], i_s_tdata[33:2]};
            r_req_trust <= i_s_tdata[71:40];
        end
    end

    // parallel compare, one comparator per row
    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            for (int e = 0; e < ENTRIES; e++) begin
                r_match[e] <= r_valid[e] && (r_keys[e] == r_req_key);
            end
            r_free <= ~r_valid;
        end
    end

    // keys are unique, so at most one match bit is set
    always_comb begin
        w_hit_idx = '0;
        for (int e = 0; e < ENTRIES; e++) begin
            if (r_match[e]) begin
                w_hit_idx = w_hit_idx | IDX_W'(e);
            end
        end
    end

    assign w_hit      = |r_match;
    assign w_free_any = |r_free;
    // isolate the lowest free row
    assign w_free_oh  = r_free & ((~r_free) + ENTRIES'(1));

    always_comb begin
        w_free_idx = '0;
        for (int e = 0; e < ENTRIES; e++) begin
            if (w_free_oh[e]) begin
                w_free_idx = w_free_idx | IDX_W'(e);
            end
        end
    end

    always_comb begin
        w_set        = 1'b0;
        w_clr        = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_wa     = w_hit_idx;
        w_status     = ptt_pkg::ST_MISS;
        w_lookup_hit = 1'b0;
        unique case (r_mode)
            ptt_pkg::MODE_LOOKUP: begin
                if (w_hit) begin
                    w_status     = ptt_pkg::ST_HIT;
                    w_lookup_hit = 1'b1;
                end
            end
            ptt_pkg::MODE_UPDATE: begin
                if (w_hit) begin
                    w_mem_we = 1'b1;
                    w_status = ptt_pkg::ST_HIT;
                end else if (w_free_any) begin
                    w_set    = 1'b1;
                    w_mem_we = 1'b1;
                    w_mem_wa = w_free_idx;
                    w_status = ptt_pkg::ST_NEW;
                end else begin
                    w_status = ptt_pkg::ST_FULL;
                end
            end
            ptt_pkg::MODE_DELETE: begin
                if (w_hit) begin
                    w_clr    = 1'b1;
                    w_status = ptt_pkg::ST_HIT;
                end
            end
            default: begin
                w_status = ptt_pkg::ST_MISS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.exec) begin
            for (int e = 0; e < ENTRIES; e++) begin
                if (w_set && w_free_oh[e]) begin
                    r_valid[e] <= 1'b1;
                end else if (w_clr && r_match[e]) begin
                    r_valid[e] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_set) begin
            for (int e = 0; e < ENTRIES; e++) begin
                if (w_free_oh[e]) begin
                    r_keys[e] <= r_req_key;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_mem_we) begin
            r_trust_mem[w_mem_wa] <= r_req_trust;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rd_trust   <= r_trust_mem[w_hit_idx];
            r_status     <= w_status;
            r_lookup_hit <= w_lookup_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.resp) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            r_out_status <= r_status;
            r_out_trust  <= r_lookup_hit ? r_rd_trust : '0;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = {{(ptt_pkg::OUT_TDATA_W - ptt_pkg::OUT_RAW_W){1'b0}},
                              r_out_trust, r_out_status};

endmodule

### src/prefix_trust_table.sv
//  channel   dir  handshake              word
//  --------  ---  ---------------------  -------------------------------------------
//  request   in   i_s_tvalid/o_s_tready  mode, prefix, plen, trust_in (72 bits)
//  result    out  o_m_tvalid/i_m_tready  status, trust_out (34 bits in 40)
//
//  each request passes capture, match (all rows compared at once),
//  execute (table write or value-memory read) and result load in turn
//  the value memory read is registered during execute, before the result register
//  synchronous active-low reset clears the row valid bits, the result valid and the controller
//  a new request is taken while the previous result still waits downstream;
//  the result load stalls only when that word has not been taken
module prefix_trust_table_core #(
    parameter int ENTRIES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // mode[1:0], prefix[33:2], plen[39:34], trust_in[71:40]
    input  logic [ptt_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // status[1:0], trust_out[33:2], zero[39:34]
    output logic [ptt_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // sequencing between controller and datapath
    ptt_pkg::t_cmd  w_cmd;
    ptt_pkg::t_stat w_stat;

    ptt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // key rows, valid bits, value memory and result register
    ptt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // one request in flight: no new word right after one is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while one is in flight");

    // the table is only changed after a fresh compare
    a_exec_after_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |-> $past(w_cmd.match))
        else $error("execute without a preceding compare");

    // at most one sequencing step per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.match, w_cmd.exec, w_cmd.resp}))
        else $error("overlapping sequencing commands");

    // a result load always shows a word on the next cycle
    a_resp_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.resp |=> o_m_tvalid)
        else $error("result load did not raise tvalid");

endmodule

### dv/tb_prefix_trust_table_core.sv
module tb_prefix_trust_table_core;

    localparam int ENTRIES        = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int HOLD_CYCLES    = 400;

    // mode value that the block ignores
    localparam logic [ptt_pkg::MODE_W-1:0] MODE_RESERVED = 2'd3;

    localparam logic signed [ptt_pkg::TRUST_W-1:0] TRUST_MIN = 32'h8000_0000;
    localparam logic signed [ptt_pkg::TRUST_W-1:0] TRUST_MAX = 32'h7fff_ffff;

    // field order matches the request word, lowest field last
    typedef struct packed {
        logic signed [ptt_pkg::TRUST_W-1:0] trust;
        logic [ptt_pkg::PLEN_W-1:0]         plen;
        logic [ptt_pkg::PREFIX_W-1:0]       prefix;
        logic [ptt_pkg::MODE_W-1:0]         mode;
    } t_trust_req;

    typedef struct packed {
        logic [ptt_pkg::STATUS_W-1:0]       status;
        logic signed [ptt_pkg::TRUST_W-1:0] trust;
    } t_trust_result;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_style;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    // mode[1:0], prefix[33:2], plen[39:34], trust_in[71:40]
    logic [ptt_pkg::IN_TDATA_W-1:0]  i_s_tdata;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    // status[1:0], trust_out[33:2], zero[39:34]
    logic [ptt_pkg::OUT_TDATA_W-1:0] o_m_tdata;

    // shadow copy of the table contents
    logic                               tbl_valid [ENTRIES];
    logic [ptt_pkg::KEY_W-1:0]          tbl_key   [ENTRIES];
    logic signed [ptt_pkg::TRUST_W-1:0] tbl_trust [ENTRIES];

    t_trust_result table_results[$];
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    int            burst_left = 0;
    bit            gap_enable = 1'b1;
    logic          rx_hold = 1'b0;
    t_rx_style     rx_style = RX_FREE;
    int            rx_style_left = 0;
    int            rx_phase = 0;

    prefix_trust_table_core #(
        .ENTRIES(ENTRIES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // index of the valid entry holding the key, -1 on a miss
    function automatic int find_entry(logic [ptt_pkg::KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_key[i] == k) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int count_used();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                n++;
            end
        end
        return n;
    endfunction

    // applies one request to the shadow table and returns the word it answers with
    function automatic t_trust_result apply_to_table(t_trust_req r);
        t_trust_result             res;
        logic [ptt_pkg::KEY_W-1:0] k;
        int                        hit_idx;
        int                        free_idx;
        res.status = ptt_pkg::ST_MISS;
        res.trust  = '0;
        k          = {r.plen, r.prefix};
        hit_idx    = find_entry(k);
        free_idx   = -1;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!tbl_valid[i]) begin
                free_idx = i;
            end
        end
        case (r.mode)
            ptt_pkg::MODE_LOOKUP: begin
                if (hit_idx >= 0) begin
                    res.status = ptt_pkg::ST_HIT;
                    res.trust  = tbl_trust[hit_idx];
                end
            end
            ptt_pkg::MODE_UPDATE: begin
                if (hit_idx >= 0) begin
                    tbl_trust[hit_idx] = r.trust;
                    res.status         = ptt_pkg::ST_HIT;
                end else if (free_idx >= 0) begin
                    tbl_valid[free_idx] = 1'b1;
                    tbl_key[free_idx]   = k;
                    tbl_trust[free_idx] = r.trust;
                    res.status          = ptt_pkg::ST_NEW;
                end else begin
                    res.status = ptt_pkg::ST_FULL;
                end
            end
            ptt_pkg::MODE_DELETE: begin
                if (hit_idx >= 0) begin
                    tbl_valid[hit_idx] = 1'b0;
                    res.status         = ptt_pkg::ST_HIT;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_trust_req make_req(logic [ptt_pkg::MODE_W-1:0] m,
                                            logic [ptt_pkg::PREFIX_W-1:0] p,
                                            logic [ptt_pkg::PLEN_W-1:0] l,
                                            logic signed [ptt_pkg::TRUST_W-1:0] t);
        t_trust_req r;
        r.mode   = m;
        r.prefix = p;
        r.plen   = l;
        r.trust  = t;
        return r;
    endfunction

    // mostly legal lengths, now and then the unchecked range above 32
    function automatic logic [ptt_pkg::PLEN_W-1:0] random_plen();
        if ($urandom_range(0, 5) == 0) begin
            return ptt_pkg::PLEN_W'($urandom_range(33, 63));
        end
        return ptt_pkg::PLEN_W'($urandom_range(0, 32));
    endfunction

    function automatic logic signed [ptt_pkg::TRUST_W-1:0] random_trust();
        case ($urandom_range(0, 9))
            0:       return TRUST_MIN;
            1:       return TRUST_MAX;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // offers one word in sender bursts and logs its answer once it is taken
    task automatic send_request(input t_trust_req r);
        int gap;
        if (gap_enable) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= r;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        table_results.push_back(apply_to_table(r));
    endtask

    // every operation on an empty and a lightly used table, edge keys and values
    task automatic test_directed_ops();
        send_request(make_req(ptt_pkg::MODE_LOOKUP, 32'h0000_0000, 6'd0,  TRUST_MAX));
        send_request(make_req(ptt_pkg::MODE_DELETE, 32'h0000_0000, 6'd0,  TRUST_MAX));
        send_request(make_req(MODE_RESERVED,        32'h0000_0000, 6'd0,  TRUST_MAX));
        send_request(make_req(ptt_pkg::MODE_UPDATE, 32'h0000_0000, 6'd0,  TRUST_MIN));
        send_request(make_req(ptt_pkg::MODE_LOOKUP, 32'h0000_0000, 6'd0,  '0));
        send_request(make_req(ptt_pkg::MODE_UPDATE, 32'hffff_ffff, 6'd32, TRUST_MAX));
        send_request(make_req(ptt_pkg::MODE_LOOKUP, 32'hffff_ffff, 6'd32, '0));
        send_request(make_req(ptt_pkg::MODE_UPDATE, 32'h0000_0000, 6'd0,  -1));
        send_request(make_req(ptt_pkg::MODE_LOOKUP, 32'h0000_0000, 6'd0,  '0));
        // same prefix, other length: must not match
        send_request(make_req(ptt_pkg::MODE_LOOKUP, 32'h0000_0000, 6'd1,  '0));
        send_request(make_req(ptt_pkg::MODE_LOOKUP, 32'hffff_ffff, 6'd31, '0));
        // length above 32 is just part of the key
        send_request(make_req(ptt_pkg::MODE_UPDATE, 32'hffff_ffff, 6'd63, 32'h5555_5555));
        send_request(make_req(ptt_pkg::MODE_LOOKUP, 32'hffff_ffff, 6'd63, '0));
        // ignored mode on a stored key leaves it untouched
        send_request(make_req(MODE_RESERVED,        32'hffff_ffff, 6'd63, '0));
        send_request(make_req(ptt_pkg::MODE_LOOKUP, 32'hffff_ffff, 6'd63, TRUST_MIN));
        send_request(make_req(ptt_pkg::MODE_DELETE, 32'h0000_0000, 6'd0,  '0));
        send_request(make_req(ptt_pkg::MODE_LOOKUP, 32'h0000_0000, 6'd0,  '0));
        send_request(make_req(ptt_pkg::MODE_DELETE, 32'h0000_0000, 6'd0,  '0));
        // freed slot gets reused
        send_request(make_req(ptt_pkg::MODE_UPDATE, 32'haaaa_aaaa, 6'd42, '0));
        send_request(make_req(ptt_pkg::MODE_LOOKUP, 32'haaaa_aaaa, 6'd42, TRUST_MAX));
        send_request(make_req(ptt_pkg::MODE_UPDATE, 32'h8000_0001, 6'd21, 32'haaaa_aaaa));
        send_request(make_req(ptt_pkg::MODE_LOOKUP, 32'h8000_0001, 6'd21, '0));
        send_request(make_req(ptt_pkg::MODE_DELETE, 32'hffff_ffff, 6'd32, '0));
    endtask

    // fill every slot, hit the full case, then empty the table again
    task automatic test_table_full();
        t_trust_req                r;
        t_trust_req                kept;
        logic [ptt_pkg::KEY_W-1:0] stored[$];
        kept = make_req(ptt_pkg::MODE_UPDATE, '0, '0, '0);
        while (count_used() < ENTRIES) begin
            r = make_req(ptt_pkg::MODE_UPDATE, $urandom, random_plen(), random_trust());
            send_request(r);
            kept = r;
        end
        repeat (4) begin
            send_request(make_req(ptt_pkg::MODE_UPDATE, $urandom, random_plen(),
                                  random_trust()));
        end
        send_request(make_req(ptt_pkg::MODE_UPDATE, kept.prefix, kept.plen, TRUST_MIN));
        send_request(make_req(ptt_pkg::MODE_LOOKUP, kept.prefix, kept.plen, '0));
        send_request(make_req(ptt_pkg::MODE_DELETE, kept.prefix, kept.plen, '0));
        send_request(make_req(ptt_pkg::MODE_UPDATE, $urandom, random_plen(), random_trust()));
        send_request(make_req(ptt_pkg::MODE_UPDATE, $urandom, random_plen(), random_trust()));
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                stored.push_back(tbl_key[i]);
            end
        end
        foreach (stored[i]) begin
            send_request(make_req(ptt_pkg::MODE_DELETE, stored[i][ptt_pkg::PREFIX_W-1:0],
                                  stored[i][ptt_pkg::KEY_W-1:ptt_pkg::PREFIX_W],
                                  random_trust()));
        end
    endtask

    // receiver holds off for a long time while words keep coming back to back
    task automatic test_backpressure();
        gap_enable = 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            begin
                for (int i = 0; i < 60; i++) begin
                    send_request(make_req(ptt_pkg::MODE_LOOKUP +
                                          ptt_pkg::MODE_W'($urandom_range(0, 2)),
                                          $urandom_range(0, 3), 6'd8, random_trust()));
                end
            end
        join
        gap_enable = 1'b1;
    endtask

    // random requests over a pool of keys, some fresh keys and some stored ones
    task automatic run_random_mix(input int n_items, input int pool_size);
        logic [ptt_pkg::KEY_W-1:0]    pool[$];
        logic [ptt_pkg::KEY_W-1:0]    k;
        logic [ptt_pkg::MODE_W-1:0]   m;
        logic [ptt_pkg::PREFIX_W-1:0] p;
        int                           pick;
        int                           idx;
        for (int i = 0; i < pool_size; i++) begin
            // some keys share a prefix with the previous one
            p = (i > 0 && $urandom_range(0, 3) == 0) ? pool[i-1][ptt_pkg::PREFIX_W-1:0]
                                                      : $urandom;
            pool.push_back({random_plen(), p});
        end
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            k    = pool[$urandom_range(0, pool_size - 1)];
            if (pick >= 90) begin
                k = {random_plen(), 32'($urandom)};
            end else if (pick >= 80 && count_used() > 0) begin
                idx = $urandom_range(0, ENTRIES - 1);
                while (!tbl_valid[idx]) idx = (idx + 1) % ENTRIES;
                k = tbl_key[idx];
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                m = ptt_pkg::MODE_LOOKUP;
            end else if (pick < 75) begin
                m = ptt_pkg::MODE_UPDATE;
            end else if (pick < 95) begin
                m = ptt_pkg::MODE_DELETE;
            end else begin
                m = MODE_RESERVED;
            end
            send_request(make_req(m, k[ptt_pkg::PREFIX_W-1:0],
                                  k[ptt_pkg::KEY_W-1:ptt_pkg::PREFIX_W], random_trust()));
        end
    endtask

    task automatic test_random_churn();
        run_random_mix(900, 100);
    endtask

    task automatic test_random_hot();
        run_random_mix(550, 10);
    endtask

    // receiver stall pattern, switching style when the current style's run ends
    always @(posedge i_clk) begin
        if (rx_style_left == 0) begin
            rx_style      <= t_rx_style'($urandom_range(0, 2));
            rx_style_left <= $urandom_range(50, 300);
        end else begin
            rx_style_left <= rx_style_left - 1;
        end
        rx_phase <= rx_phase + 1;
        if (rx_hold) begin
            i_m_tready <= 1'b0;
        end else begin
            case (rx_style)
                RX_FREE:   i_m_tready <= 1'b1;
                RX_RANDOM: i_m_tready <= ($urandom_range(0, 99) < 60);
                default:   i_m_tready <= ((rx_phase % 7) < 3);
            endcase
        end
    end

    // compare every result word with the oldest pending answer
    always @(posedge i_clk) begin : result_check
        t_trust_result want;
        t_trust_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status = o_m_tdata[ptt_pkg::STATUS_W-1:0];
            got.trust  = o_m_tdata[ptt_pkg::STATUS_W+ptt_pkg::TRUST_W-1:ptt_pkg::STATUS_W];
            if (table_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result word expected none, actual status %0d trust %0d",
                         $realtime, got.status, got.trust);
            end else begin
                want = table_results.pop_front();
                if (got.status != want.status) begin
                    mismatch_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.status, got.status);
                end
                if (got.trust != want.trust) begin
                    mismatch_count++;
                    $display("%0t: trust_out expected %0d actual %0d",
                             $realtime, want.trust, got.trust);
                end
            end
        end
    end

    // stop when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_trust[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_table_full();
        test_backpressure();
        test_random_churn();
        test_random_hot();

        i_s_tvalid <= 1'b0;
        while (table_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
